// ===== sv/sfpc_pkg.sv =====
// ----------------------------------------------------------------------------
// sfpc_pkg
// shared types and codes for the sparse fixed point convolution block
// ----------------------------------------------------------------------------
package sfpc_pkg;

  // input operation codes
  localparam logic [1:0] OP_TAP_WR  = 2'd0;
  localparam logic [1:0] OP_PIX_WR  = 2'd1;
  localparam logic [1:0] OP_COMPUTE = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_TAP_COUNT   = 2'd0;
  localparam logic [1:0] CFG_ROUND_SHIFT = 2'd1;
  localparam logic [1:0] CFG_OUTPUT_BIAS = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_ROUND,
    ST_EMIT
  } state_t;

  // one tap table entry
  typedef struct packed {
    logic signed [15:0] coef;
    logic [11:0]        offset;
  } tap_t;

  // datapath strobes from the sequencer
  typedef struct packed {
    logic clear;      // start of a compute beat
    logic load_coef;  // tap read data valid
    logic mult;       // pixel read data valid
    logic accum;      // product valid
    logic round;      // add rounding term
  } mac_ctrl_t;

endpackage

// ===== sv/sparse_fixed_point_convolution.sv =====
// ----------------------------------------------------------------------------
// sparse_fixed_point_convolution
// 8-bit image convolution over a list of non-zero fixed point taps
// ----------------------------------------------------------------------------
//   channel  signals                             dir  notes
//   in       in_valid in_stall op tap_index ...  in   tap write, pixel write, compute
//   out      out_valid out_stall out_pixel       out  one beat per compute
//   cfg      cfg_write cfg_index cfg_data        in   tap_count, round_shift, output_bias
//
// a write beat is taken without raising in_stall; a compute beat holds in_stall
// until its output load: n = min(tap_count, MAX_TAPS) tap reads, one per cycle,
// feed a pixel read, multiply and accumulate pipeline, then a drain check, rounding, output load
// its pixel is registered at the output load; new beats are taken while it
// waits on out_stall, only the next compute end waits for it
// reset is synchronous and clears config and control; memories hold garbage
// until written.
// ----------------------------------------------------------------------------
module sparse_fixed_point_convolution #(
  parameter int MAX_TAPS    = 64,
  parameter int STORE_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [5:0]  tap_index,
  input  logic signed [15:0] tap_coef,
  input  logic [11:0] tap_offset,
  input  logic [11:0] pixel_address,
  input  logic [7:0]  pixel_value,
  input  logic [11:0] base_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_pixel,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int TW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(MAX_TAPS + 1);
  localparam logic [CW-1:0] MAX_N = CW'(MAX_TAPS);

  // wrap a store address by repeated compare and subtract
  function automatic logic [AW-1:0] wrap_addr(input logic [12:0] v);
    logic [31:0] w;
    w = {19'd0, v};
    for (int k = 7; k >= 0; k--) begin
      if (w >= (32'(STORE_DEPTH) << k)) begin
        w = w - (32'(STORE_DEPTH) << k);
      end
    end
    return w[AW-1:0];
  endfunction

  function automatic logic [TW-1:0] wrap_tap(input logic [5:0] v);
    logic [31:0] w;
    w = {26'd0, v};
    for (int k = 5; k >= 0; k--) begin
      if (w >= (32'(MAX_TAPS) << k)) begin
        w = w - (32'(MAX_TAPS) << k);
      end
    end
    return w[TW-1:0];
  endfunction

  logic [6:0]         tap_count;
  logic [4:0]         round_shift;
  logic signed [15:0] output_bias;

  sfpc_pkg::state_t    state, state_next;
  sfpc_pkg::mac_ctrl_t ctrl;
  sfpc_pkg::tap_t      tap_wr_data;
  sfpc_pkg::tap_t      tap_rd_data;

  logic [CW-1:0] cnt;
  logic [CW-1:0] n_taps;
  logic [11:0]   base;
  logic          v1, v2, v3;
  logic          in_take;
  logic          start;
  logic          issue;
  logic          drained;
  logic          out_free;
  logic          emit;
  logic [7:0]    pix_rd_data;
  logic [AW-1:0] pix_rd_addr;
  logic [7:0]    result;

  assign n_taps = ({25'd0, tap_count} > 32'(MAX_TAPS)) ? MAX_N : CW'(tap_count);

  assign in_stall = (state != sfpc_pkg::ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign start    = in_take && (op == sfpc_pkg::OP_COMPUTE);
  assign issue    = (state == sfpc_pkg::ST_RUN) && (cnt != n_taps);
  assign drained  = (cnt == n_taps) && !v1 && !v2 && !v3;
  assign out_free = !out_valid || !out_stall;
  assign emit     = (state == sfpc_pkg::ST_EMIT) && out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count   <= 7'd0;
      round_shift <= 5'd1;
      output_bias <= 16'sd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        sfpc_pkg::CFG_TAP_COUNT:   tap_count   <= cfg_data[6:0];
        sfpc_pkg::CFG_ROUND_SHIFT: round_shift <= cfg_data[4:0];
        sfpc_pkg::CFG_OUTPUT_BIAS: output_bias <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sfpc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sfpc_pkg::ST_IDLE:  if (start) state_next = sfpc_pkg::ST_RUN;
      sfpc_pkg::ST_RUN:   if (drained) state_next = sfpc_pkg::ST_ROUND;
      sfpc_pkg::ST_ROUND: state_next = sfpc_pkg::ST_EMIT;
      sfpc_pkg::ST_EMIT:  if (out_free) state_next = sfpc_pkg::ST_IDLE;
    endcase
  end

  // tap issue counter and read pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
    end else begin
      if (start) begin
        cnt <= '0;
      end else if (issue) begin
        cnt <= cnt + 1'b1;
      end
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      base <= base_address;
    end
  end

  assign tap_wr_data = '{coef: tap_coef, offset: tap_offset};

  sfpc_tap_ram #(
    .DEPTH (MAX_TAPS),
    .AW    (TW)
  ) u_tap_ram (
    .clk     (clk),
    .wr_en   (in_take && (op == sfpc_pkg::OP_TAP_WR)),
    .wr_addr (wrap_tap(tap_index)),
    .wr_data (tap_wr_data),
    .rd_en   (issue),
    .rd_addr (cnt[TW-1:0]),
    .rd_data (tap_rd_data)
  );

  // tap offsets wrap around the store
  assign pix_rd_addr = wrap_addr({1'b0, base} + {1'b0, tap_rd_data.offset});

  sfpc_pix_ram #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW)
  ) u_pix_ram (
    .clk     (clk),
    .wr_en   (in_take && (op == sfpc_pkg::OP_PIX_WR)),
    .wr_addr (wrap_addr({1'b0, pixel_address})),
    .wr_data (pixel_value),
    .rd_en   (v1),
    .rd_addr (pix_rd_addr),
    .rd_data (pix_rd_data)
  );

  assign ctrl = '{
    clear:     start,
    load_coef: v1,
    mult:      v2,
    accum:     v3,
    round:     (state == sfpc_pkg::ST_ROUND)
  };

  sfpc_mac u_mac (
    .clk         (clk),
    .ctrl        (ctrl),
    .coef_in     (tap_rd_data.coef),
    .pix_in      (pix_rd_data),
    .round_shift (round_shift),
    .output_bias (output_bias),
    .result      (result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_pixel <= result;
    end
  end

  // never issue past the active tap count
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == sfpc_pkg::ST_RUN) |-> (cnt <= n_taps))
    else $error("tap counter ran past tap count");

  // every read has reached the accumulator before rounding
  a_drained: assert property (@(posedge clk) disable iff (rst)
    (state == sfpc_pkg::ST_ROUND) |-> (!v1 && !v2 && !v3))
    else $error("rounding with products still in flight");

  // a compute beat starts the tap sweep from entry zero
  a_start: assert property (@(posedge clk) disable iff (rst)
    start |=> ((state == sfpc_pkg::ST_RUN) && (cnt == '0) && !v1))
    else $error("compute did not start a fresh sweep");

  // a new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit |-> !(out_valid && out_stall))
    else $error("result register overwritten");

endmodule

// ===== sv/sfpc_tap_ram.sv =====
// ----------------------------------------------------------------------------
// sfpc_tap_ram
// tap table: coefficient and offset per entry, one write and one read port
// ----------------------------------------------------------------------------
module sfpc_tap_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  sfpc_pkg::tap_t  wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output sfpc_pkg::tap_t  rd_data
);

  sfpc_pkg::tap_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/sfpc_pix_ram.sv =====
// ----------------------------------------------------------------------------
// sfpc_pix_ram
// pixel store: 8-bit samples, one write and one read port
// ----------------------------------------------------------------------------
module sfpc_pix_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/sfpc_mac.sv =====
// ----------------------------------------------------------------------------
// sfpc_mac
// multiply-accumulate, rounding and output saturation
// ----------------------------------------------------------------------------
module sfpc_mac (
  input  logic                  clk,
  input  sfpc_pkg::mac_ctrl_t   ctrl,
  input  logic signed [15:0]    coef_in,
  input  logic [7:0]            pix_in,
  input  logic [4:0]            round_shift,
  input  logic signed [15:0]    output_bias,
  output logic [7:0]            result
);

  logic signed [15:0] coef;
  logic signed [24:0] prod;
  logic [31:0]        acc;
  logic [31:0]        rnd;
  logic [31:0]        rterm;
  logic signed [31:0] shifted;
  logic signed [32:0] biased;

  assign rterm = (round_shift == 5'd0) ? 32'd0 : (32'd1 << (round_shift - 5'd1));

  always_ff @(posedge clk) begin
    if (ctrl.load_coef) begin
      coef <= coef_in;
    end
    if (ctrl.mult) begin
      prod <= coef * $signed({1'b0, pix_in});
    end
    // accumulator wraps modulo 2^32
    if (ctrl.clear) begin
      acc <= 32'd0;
    end else if (ctrl.accum) begin
      acc <= acc + {{7{prod[24]}}, prod};
    end
    if (ctrl.round) begin
      rnd <= acc + rterm;
    end
  end

  always_comb begin
    shifted = $signed(rnd) >>> round_shift;
    biased  = {shifted[31], shifted} + {{17{output_bias[15]}}, output_bias};
    if (biased < 0) begin
      result = 8'd0;
    end else if (biased > 33'sd255) begin
      result = 8'd255;
    end else begin
      result = biased[7:0];
    end
  end

endmodule
